// File: sv/ipt_pkg.sv
// package: shared types, constants and codes for the interpolated power table lookup
`default_nettype none
package ipt_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int ROBOTS_DEF  = 16;

	localparam int LEN_W    = 7;
	localparam int ROBOT_W  = 4;
	localparam int INDEX_W  = 6;
	localparam int DIST_W   = 16;
	localparam int POWER_W  = 16;
	localparam int DEN_W    = LEN_W + DIST_W;
	localparam int REM_W    = DEN_W + 1;
	localparam int CNT_W    = $clog2(POWER_W);
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [POWER_W-1:0] FULL_POWER = POWER_W'(32768);
	localparam logic [LEN_W-1:0]   LEN_RESET  = LEN_W'(2);

	localparam logic REG_TABLE_LENGTH = 1'b0;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [0:0]         cmd;
		logic [ROBOT_W-1:0] robot;
		logic [INDEX_W-1:0] entry_index;
		logic [DIST_W-1:0]  entry_distance;
		logic [DIST_W-1:0]  query_distance;
	} req_word_t;

	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic               out_of_table;
		logic               flat_segment;
	} rsp_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_CK0,
		ST_CKH,
		ST_SRCH,
		ST_CMP,
		ST_GLO,
		ST_GHI,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_HI,
		RD_MID,
		RD_LO
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_BELOW,
		RES_ABOVE
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     mem_we;
		rd_sel_t  rd_sel;
		logic     cap_mid;
		logic     step;
		logic     cap_d1;
		logic     cap_d2;
		logic     prep;
		logic     mul;
		logic     div_step;
		res_sel_t res_sel;
		logic     out_load;
	} ctl_t;

	typedef struct packed {
		logic is_query;
		logic robot_bad;
		logic q_below;
		logic q_above;
		logic wide;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: sv/interpolated_power_table_lookup.sv
// top level: configuration registers, controller and datapath of the power table lookup
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  req_word_t (cmd, robot, entry, distances)
//  rsp       out        rsp_valid / rsp_stall  rsp_word_t (power, out_of_table, flat_segment)
//  apb       in/out     psel / penable / pready  table_length at byte address 0
//
// a write word is stored straight from idle; a query makes one table read per search step
// over L, the entries in use, then runs a restoring divider with one step per quotient bit
// a query outside the table or for an unknown robot skips the search and the division
// a new word is taken while a finished word still waits on rsp_stall
// reset clears the controller, the output valid and table_length (to 2); the table is
// undefined until written
`default_nettype none
module interpolated_power_table_lookup import ipt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int ROBOTS  = ROBOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_word_t          req_word,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_word_t               rsp_word,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [LEN_W-1:0] table_length_q;
	ctl_t             ctl;
	sts_t             sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= LEN_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[PADDR_W-1] == REG_TABLE_LENGTH) begin
			table_length_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_TABLE_LENGTH) ? PDATA_W'(table_length_q) : '0;

	ipt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.ctl       (ctl),
		.req_stall (req_stall)
	);

	ipt_dp #(
		.ENTRIES (ENTRIES),
		.ROBOTS  (ROBOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_word     (req_word),
		.table_length (table_length_q),
		.ctl          (ctl),
		.sts          (sts),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_word     (rsp_word)
	);

endmodule
`default_nettype wire

// File: sv/ipt_ctrl.sv
// controller: sequences search, interpolation and division for one word
`default_nettype none
module ipt_ctrl import ipt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire sts_t sts,
	output ctl_t      ctl,
	output logic      req_stall
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && sts.is_query) state_nxt = ST_RD0;
			end
			ST_RD0: begin
				if (sts.robot_bad) state_nxt = ST_DONE;
				else state_nxt = ST_CK0;
			end
			ST_CK0: begin
				if (sts.q_below) state_nxt = ST_DONE;
				else state_nxt = ST_CKH;
			end
			ST_CKH: begin
				if (sts.q_above) state_nxt = ST_DONE;
				else state_nxt = ST_SRCH;
			end
			ST_SRCH: begin
				if (sts.wide) state_nxt = ST_CMP;
				else state_nxt = ST_GLO;
			end
			ST_CMP:  state_nxt = ST_SRCH;
			ST_GLO:  state_nxt = ST_GHI;
			ST_GHI:  state_nxt = ST_PREP;
			ST_PREP: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		ctl.rd_sel  = RD_ZERO;
		ctl.res_sel = RES_NONE;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall  = 1'b0;
				ctl.load   = req_valid && sts.is_query;
				ctl.mem_we = req_valid && !sts.is_query;
			end
			ST_RD0: begin
				ctl.rd_sel = RD_ZERO;
				if (sts.robot_bad) ctl.res_sel = RES_BELOW;
			end
			ST_CK0: begin
				ctl.rd_sel = RD_HI;
				if (sts.q_below) ctl.res_sel = RES_BELOW;
			end
			ST_CKH: begin
				if (sts.q_above) ctl.res_sel = RES_ABOVE;
			end
			ST_SRCH: begin
				if (sts.wide) begin
					ctl.rd_sel  = RD_MID;
					ctl.cap_mid = 1'b1;
				end else begin
					ctl.rd_sel = RD_LO;
				end
			end
			ST_CMP:  ctl.step = 1'b1;
			ST_GLO: begin
				ctl.cap_d1 = 1'b1;
				ctl.rd_sel = RD_HI;
			end
			ST_GHI:  ctl.cap_d2 = 1'b1;
			ST_PREP: ctl.prep = 1'b1;
			ST_MUL:  ctl.mul = 1'b1;
			ST_DIV:  ctl.div_step = 1'b1;
			ST_DONE: ctl.out_load = sts.out_free;
			default: ctl.load = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/ipt_dp.sv
// datapath: distance table memory, search bounds, interpolation and restoring divider
`default_nettype none
module ipt_dp import ipt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int ROBOTS  = ROBOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_word_t        req_word,
	input  wire logic [LEN_W-1:0] table_length,
	input  wire ctl_t             ctl,
	output sts_t                  sts,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_word_t             rsp_word
);

	localparam int DEPTH = ROBOTS * ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(ENTRIES);

	logic [DIST_W-1:0] mem [DEPTH];
	logic [DIST_W-1:0] rd_data_q;

	logic [ROBOT_W-1:0] robot_q;
	logic [DIST_W-1:0]  q_q;
	logic [IW-1:0]      lo_q;
	logic [IW-1:0]      hi_q;
	logic [IW-1:0]      mid_q;
	logic [DIST_W-1:0]  d1_q;
	logic [DIST_W-1:0]  d2_q;
	logic [DIST_W-1:0]  span_q;
	logic [DIST_W-1:0]  off_q;
	logic               flat_q;
	logic               oot_q;
	logic [REM_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [POWER_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rsp_valid_q;
	rsp_word_t          rsp_word_q;

	logic [LEN_W-1:0]   len_m1;
	logic [IW:0]        mid_sum;
	logic [IW-1:0]      mid;
	logic [IW-1:0]      rd_idx;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               wr_ok;
	logic [DIST_W-1:0]  span_c;
	logic [DIST_W-1:0]  off_c;
	logic [LEN_W-1:0]   lo_n;
	logic               ge;
	logic [REM_W-1:0]   sub;

	// entries in use, saturated to 2..ENTRIES, minus one
	always_comb begin
		if (table_length < LEN_W'(2)) begin
			len_m1 = LEN_W'(1);
		end else if (int'(table_length) > ENTRIES) begin
			len_m1 = LEN_W'(ENTRIES - 1);
		end else begin
			len_m1 = table_length - LEN_W'(1);
		end
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IW:1];

	always_comb begin
		case (ctl.rd_sel)
			RD_ZERO: rd_idx = '0;
			RD_HI:   rd_idx = hi_q;
			RD_MID:  rd_idx = mid;
			RD_LO:   rd_idx = lo_q;
			default: rd_idx = '0;
		endcase
	end

	assign rd_addr = AW'(int'(robot_q) * ENTRIES + int'(rd_idx));
	assign wr_addr = AW'(int'(req_word.robot) * ENTRIES + int'(req_word.entry_index));
	assign wr_ok   = (int'(req_word.robot) < ROBOTS) && (int'(req_word.entry_index) < ENTRIES);

	always_ff @(posedge clk) begin
		if (ctl.mem_we && wr_ok) begin
			mem[wr_addr] <= req_word.entry_distance;
		end
		rd_data_q <= mem[rd_addr];
	end

	// offset into the bracketing pair, clamped to the pair
	always_comb begin
		span_c = d2_q - d1_q;
		off_c  = (q_q > d1_q) ? (q_q - d1_q) : '0;
		if (off_c > span_c) off_c = span_c;
	end

	assign lo_n = LEN_W'(lo_q);
	assign ge   = rem_q >= REM_W'(den_q);
	assign sub  = ge ? (rem_q - REM_W'(den_q)) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.mul) begin
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			robot_q <= req_word.robot;
			q_q     <= req_word.query_distance;
			lo_q    <= '0;
			hi_q    <= IW'(len_m1);
		end
		if (ctl.cap_mid) mid_q <= mid;
		if (ctl.step) begin
			if (rd_data_q > q_q) hi_q <= mid_q;
			else lo_q <= mid_q;
		end
		if (ctl.cap_d1) d1_q <= rd_data_q;
		if (ctl.cap_d2) d2_q <= rd_data_q;
		if (ctl.prep) begin
			flat_q <= (d2_q <= d1_q);
			oot_q  <= 1'b0;
			span_q <= span_c;
			off_q  <= off_c;
		end
		if (ctl.mul) begin
			quo_q <= '0;
			if (flat_q) begin
				rem_q <= REM_W'(lo_n);
				den_q <= DEN_W'(len_m1);
			end else begin
				rem_q <= REM_W'(DEN_W'(lo_n) * DEN_W'(span_q) + DEN_W'(off_q));
				den_q <= DEN_W'(len_m1) * DEN_W'(span_q);
			end
		end
		if (ctl.div_step) begin
			rem_q <= {sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[POWER_W-2:0], ge};
		end
		case (ctl.res_sel)
			RES_BELOW: begin
				quo_q  <= '0;
				oot_q  <= 1'b1;
				flat_q <= 1'b0;
			end
			RES_ABOVE: begin
				quo_q  <= FULL_POWER;
				oot_q  <= 1'b1;
				flat_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_word_q.power        <= quo_q;
			rsp_word_q.out_of_table <= oot_q;
			rsp_word_q.flat_segment <= flat_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	assign sts.is_query  = (req_word.cmd == CMD_QUERY);
	assign sts.robot_bad = int'(robot_q) >= ROBOTS;
	assign sts.q_below   = q_q < rd_data_q;
	assign sts.q_above   = q_q > rd_data_q;
	assign sts.wide      = (hi_q - lo_q) > IW'(1);
	assign sts.div_last  = cnt_q == CNT_W'(POWER_W - 1);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

endmodule
`default_nettype wire

// File: sv/ipt_chk.sv
// checker: port-level assertions for the power table lookup, bound to the top level
`default_nettype none
module ipt_chk import ipt_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_stall,
	input wire req_word_t          req_word,
	input wire logic               rsp_valid,
	input wire logic               rsp_stall,
	input wire rsp_word_t          rsp_word,
	input wire logic               pready
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("rsp word changed while stalled");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.power <= FULL_POWER)
		else $error("power above full scale");

	// saturated words carry no flat flag and sit at an end of the range
	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.out_of_table |->
			!rsp_word.flat_segment && (rsp_word.power == '0 || rsp_word.power == FULL_POWER))
		else $error("bad saturated word");

	// a query keeps the block busy on the following cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.cmd == CMD_QUERY |=> req_stall)
		else $error("query not followed by stall");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind interpolated_power_table_lookup ipt_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_word  (req_word),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word),
	.pready    (pready)
);
`default_nettype wire
